@@ sv/atd_pkg.sv @@
package atd_pkg;

	// Result status codes.
	typedef logic [1:0] status_t;

	localparam status_t ST_OK           = 2'd0;
	localparam status_t ST_W_ZERO       = 2'd1;
	localparam status_t ST_ZERO_COLUMN  = 2'd2;
	localparam status_t ST_BAD_RADICAND = 2'd3;

	// Element index of the w element, which triggers a result.
	localparam logic [3:0] W_INDEX = 4'd15;

	// Row code of the perspective elements, which are not stored.
	localparam logic [1:0] PERSP_ROW = 2'd3;

endpackage

@@ sv/affine_transform_decompose.sv @@
// Channel  | Handshake            | Fields
// input    | in_valid, in_stall   | element_index, element_value
// output   | out_valid, out_stall | status, translation_*, scale_*, quat_*
//
// A stored element is written into the matrix when it is accepted; a zero w element goes
// straight to the done state. Any other w element runs on the XW-bit bit-serial square root
// and restoring divider, XW being max(2*DATA_WIDTH, 2*FRAC_BITS+4, DATA_WIDTH+FRAC_BITS)
// rounded up to even; a zero-length column or a non-positive radicand ends it early. Reset
// clears the stored matrix. A result waits in the output register; the input stalls while
// a decomposition runs or while that result is stalled.
module affine_transform_decompose #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [3:0]                   element_index,
	input  logic signed [DATA_WIDTH-1:0] element_value,
	output logic                         out_valid,
	input  logic                         out_stall,
	output atd_pkg::status_t             status,
	output logic signed [DATA_WIDTH-1:0] translation_x,
	output logic signed [DATA_WIDTH-1:0] translation_y,
	output logic signed [DATA_WIDTH-1:0] translation_z,
	output logic [DATA_WIDTH-2:0]        scale_x,
	output logic [DATA_WIDTH-2:0]        scale_y,
	output logic [DATA_WIDTH-2:0]        scale_z,
	output logic signed [DATA_WIDTH-1:0] quat_x,
	output logic signed [DATA_WIDTH-1:0] quat_y,
	output logic signed [DATA_WIDTH-1:0] quat_z,
	output logic signed [DATA_WIDTH-1:0] quat_w
);
	import atd_pkg::*;

	localparam int W  = DATA_WIDTH;
	localparam int F  = FRAC_BITS;
	localparam int XA = (2 * W > 2 * F + 4) ? 2 * W : 2 * F + 4;
	localparam int XB = (W + F > XA) ? W + F : XA;
	localparam int XW = XB + XB % 2;
	localparam int NW = F + 4;
	localparam int RW = F + 3;
	localparam int SC = $clog2(XW);

	localparam logic [XW-1:0] SMAX_X = {{(XW-W+1){1'b0}}, {(W-1){1'b1}}};
	localparam logic [XW-1:0] HALF_X = {{(XW-W){1'b0}}, 1'b1, {(W-1){1'b0}}};
	localparam logic signed [NW-1:0] ONE_N = {3'b000, 1'b1, {F{1'b0}}};

	typedef enum logic [3:0] {
		S_IDLE, S_SQ, S_SQRT, S_NORM_LD, S_NORM_RUN,
		S_TRACE, S_RSQRT, S_QT_LD, S_QT_RUN, S_DONE
	} state_t;

	function automatic logic [W-1:0] mag_w(input logic [W-1:0] x);
		return x[W-1] ? (~x + 1'b1) : x;
	endfunction

	function automatic logic [NW-1:0] mag_n(input logic [NW-1:0] x);
		return x[NW-1] ? (~x + 1'b1) : x;
	endfunction

	// Signed saturation of a sign and magnitude to the data width.
	function automatic logic [W-1:0] sat_q(input logic neg, input logic [XW-1:0] m);
		logic [W-1:0] res;
		if (!neg) begin
			res = (m > SMAX_X) ? SMAX_X[W-1:0] : m[W-1:0];
		end else begin
			res = (m > HALF_X) ? HALF_X[W-1:0] : (~m[W-1:0] + 1'b1);
		end
		return res;
	endfunction

	function automatic logic [W-2:0] sat_len(input logic [W-1:0] l);
		return l[W-1] ? {(W-1){1'b1}} : l[W-2:0];
	endfunction

	state_t                state_q;
	logic [W-1:0]          mat_q [12];
	logic [W-1:0]          len_q [3];
	logic signed [NW-1:0]  n_q [9];
	logic [W-1:0]          q_q [4];
	logic signed [NW-1:0]  diff_q [3];
	logic [1:0]            dst_q [3];
	logic [1:0]            c_q, r_q, k_q;
	logic [SC-1:0]         cnt_q;
	logic [2*W-1:0]        prod_q;
	logic [XW-1:0]         acc_q;
	logic [XW-1:0]         sq_op_q, sq_root_q;
	logic [XW+1:0]         sq_rem_q;
	logic [XW-1:0]         dv_num_q, dv_den_q;
	logic [XW:0]           dv_rem_q;
	logic                  neg_q;
	logic [RW-1:0]         root_q;
	status_t               status_q;
	logic                  out_valid_q;
	status_t               o_status_q;
	logic [W-1:0]          o_tr_q [3];
	logic [W-2:0]          o_sc_q [3];
	logic [W-1:0]          o_qt_q [4];

	logic                  in_acc;
	logic [3:0]            sel, wslot;
	logic [W-1:0]          cur_mag;
	logic [XW-1:0]         acc_n;

	// Handshake and element addressing.
	assign in_stall = (state_q != S_IDLE) || (out_valid_q && out_stall);
	assign in_acc   = in_valid && !in_stall;
	assign sel      = {1'b0, c_q, 1'b0} + {2'b00, c_q} + {2'b00, r_q};
	assign wslot    = {1'b0, element_index[3:2], 1'b0} + {2'b00, element_index[3:2]}
	                + {2'b00, element_index[1:0]};
	assign cur_mag  = mag_w(mat_q[sel]);
	assign acc_n    = acc_q + ((r_q != 2'd0) ? XW'(prod_q) : '0);

	// One step of the digit-by-digit square root.
	logic [XW+1:0] sq_sh, sq_trial, sq_rem_n;
	logic [XW-1:0] sq_root_n;
	logic          sq_ge;
	always_comb begin
		sq_sh     = {sq_rem_q[XW-1:0], sq_op_q[XW-1:XW-2]};
		sq_trial  = {sq_root_q, 2'b01};
		sq_ge     = (sq_sh >= sq_trial);
		sq_rem_n  = sq_ge ? (sq_sh - sq_trial) : sq_sh;
		sq_root_n = {sq_root_q[XW-2:0], sq_ge};
	end

	// One step of the restoring divider.
	logic [XW:0]   dv_sh, dv_rem_n;
	logic [XW-1:0] dv_num_n;
	logic          dv_ge;
	always_comb begin
		dv_sh    = {dv_rem_q[XW-1:0], dv_num_q[XW-1]};
		dv_ge    = (dv_sh >= {1'b0, dv_den_q});
		dv_rem_n = dv_ge ? (dv_sh - {1'b0, dv_den_q}) : dv_sh;
		dv_num_n = {dv_num_q[XW-2:0], dv_ge};
	end

	// Quaternion branch selection from the normalized diagonal.
	logic signed [NW-1:0] tr, mx, rad_c;
	logic signed [NW-1:0] d_c [3];
	logic [1:0]           dst_c [3];
	logic [1:0]           half_c, pick;
	logic                 pick1;
	always_comb begin
		tr    = n_q[0] + n_q[4] + n_q[8];
		pick1 = (n_q[4] > n_q[0]);
		mx    = pick1 ? n_q[4] : n_q[0];
		pick  = (n_q[8] > mx) ? 2'd2 : (pick1 ? 2'd1 : 2'd0);
		if (tr > 0) begin
			rad_c    = tr + ONE_N;
			half_c   = 2'd3;
			d_c[0]   = n_q[5] - n_q[7];
			d_c[1]   = n_q[6] - n_q[2];
			d_c[2]   = n_q[1] - n_q[3];
			dst_c[0] = 2'd0;
			dst_c[1] = 2'd1;
			dst_c[2] = 2'd2;
		end else begin
			unique case (pick)
				2'd0: begin
					rad_c    = n_q[0] - n_q[4] - n_q[8] + ONE_N;
					half_c   = 2'd0;
					d_c[0]   = n_q[1] + n_q[3];
					d_c[1]   = n_q[2] + n_q[6];
					d_c[2]   = n_q[5] - n_q[7];
					dst_c[0] = 2'd1;
					dst_c[1] = 2'd2;
					dst_c[2] = 2'd3;
				end
				2'd1: begin
					rad_c    = n_q[4] - n_q[8] - n_q[0] + ONE_N;
					half_c   = 2'd1;
					d_c[0]   = n_q[5] + n_q[7];
					d_c[1]   = n_q[3] + n_q[1];
					d_c[2]   = n_q[6] - n_q[2];
					dst_c[0] = 2'd2;
					dst_c[1] = 2'd0;
					dst_c[2] = 2'd3;
				end
				default: begin
					rad_c    = n_q[8] - n_q[0] - n_q[4] + ONE_N;
					half_c   = 2'd2;
					d_c[0]   = n_q[6] + n_q[2];
					d_c[1]   = n_q[7] + n_q[5];
					d_c[2]   = n_q[1] - n_q[3];
					dst_c[0] = 2'd0;
					dst_c[1] = 2'd1;
					dst_c[2] = 2'd3;
				end
			endcase
		end
	end

	// Sequencer, stored matrix and result registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			status_q    <= ST_OK;
			c_q         <= '0;
			r_q         <= '0;
			k_q         <= '0;
			cnt_q       <= '0;
			for (int i = 0; i < 12; i++) mat_q[i] <= '0;
		end else begin
			if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (element_index != W_INDEX) begin
							if (element_index[1:0] != PERSP_ROW)
								mat_q[wslot] <= element_value;
						end else if (element_value == '0) begin
							status_q <= ST_W_ZERO;
							state_q  <= S_DONE;
						end else begin
							status_q <= ST_OK;
							c_q      <= '0;
							r_q      <= '0;
							acc_q    <= '0;
							for (int i = 0; i < 4; i++) q_q[i] <= '0;
							state_q  <= S_SQ;
						end
					end
				end
				S_SQ: begin
					if (r_q != 2'd3) prod_q <= cur_mag * cur_mag;
					acc_q <= acc_n;
					r_q   <= r_q + 2'd1;
					if (r_q == 2'd3) begin
						sq_op_q   <= acc_n;
						sq_rem_q  <= '0;
						sq_root_q <= '0;
						cnt_q     <= '0;
						state_q   <= S_SQRT;
					end
				end
				S_SQRT: begin
					sq_op_q   <= {sq_op_q[XW-3:0], 2'b00};
					sq_rem_q  <= sq_rem_n;
					sq_root_q <= sq_root_n;
					cnt_q     <= cnt_q + 1'b1;
					if (cnt_q == SC'(XW / 2 - 1)) begin
						len_q[c_q] <= sq_root_n[W-1:0];
						r_q        <= '0;
						if (c_q == 2'd2) begin
							c_q <= '0;
							if (len_q[0] == '0 || len_q[1] == '0 || sq_root_n == '0) begin
								status_q <= ST_ZERO_COLUMN;
								state_q  <= S_DONE;
							end else begin
								state_q <= S_NORM_LD;
							end
						end else begin
							c_q     <= c_q + 2'd1;
							acc_q   <= '0;
							state_q <= S_SQ;
						end
					end
				end
				S_NORM_LD: begin
					dv_num_q <= XW'(cur_mag) << F;
					dv_den_q <= XW'(len_q[c_q]);
					dv_rem_q <= '0;
					neg_q    <= mat_q[sel][W-1];
					cnt_q    <= '0;
					state_q  <= S_NORM_RUN;
				end
				S_NORM_RUN: begin
					dv_num_q <= dv_num_n;
					dv_rem_q <= dv_rem_n;
					cnt_q    <= cnt_q + 1'b1;
					if (cnt_q == SC'(XW - 1)) begin
						n_q[sel] <= neg_q ? -signed'(dv_num_n[NW-1:0])
						                  : signed'(dv_num_n[NW-1:0]);
						state_q  <= S_NORM_LD;
						if (r_q == 2'd2) begin
							r_q <= '0;
							c_q <= c_q + 2'd1;
							if (c_q == 2'd2) state_q <= S_TRACE;
						end else begin
							r_q <= r_q + 2'd1;
						end
					end
				end
				S_TRACE: begin
					for (int i = 0; i < 3; i++) begin
						diff_q[i] <= d_c[i];
						dst_q[i]  <= dst_c[i];
					end
					k_q <= half_c;
					if (rad_c <= 0) begin
						status_q <= ST_BAD_RADICAND;
						state_q  <= S_DONE;
					end else begin
						sq_op_q   <= XW'(unsigned'(rad_c)) << F;
						sq_rem_q  <= '0;
						sq_root_q <= '0;
						cnt_q     <= '0;
						state_q   <= S_RSQRT;
					end
				end
				S_RSQRT: begin
					sq_op_q   <= {sq_op_q[XW-3:0], 2'b00};
					sq_rem_q  <= sq_rem_n;
					sq_root_q <= sq_root_n;
					cnt_q     <= cnt_q + 1'b1;
					if (cnt_q == SC'(XW / 2 - 1)) begin
						root_q   <= sq_root_n[RW-1:0];
						q_q[k_q] <= sat_q(1'b0, sq_root_n >> 1);
						k_q      <= '0;
						state_q  <= S_QT_LD;
					end
				end
				S_QT_LD: begin
					dv_num_q <= XW'(mag_n(diff_q[k_q])) << F;
					dv_den_q <= XW'({root_q, 1'b0});
					dv_rem_q <= '0;
					neg_q    <= diff_q[k_q][NW-1];
					cnt_q    <= '0;
					state_q  <= S_QT_RUN;
				end
				S_QT_RUN: begin
					dv_num_q <= dv_num_n;
					dv_rem_q <= dv_rem_n;
					cnt_q    <= cnt_q + 1'b1;
					if (cnt_q == SC'(XW - 1)) begin
						q_q[dst_q[k_q]] <= sat_q(neg_q, dv_num_n);
						k_q             <= k_q + 2'd1;
						state_q         <= (k_q == 2'd2) ? S_DONE : S_QT_LD;
					end
				end
				S_DONE: begin
					o_status_q <= status_q;
					for (int i = 0; i < 3; i++) begin
						o_tr_q[i] <= (status_q == ST_W_ZERO) ? '0 : mat_q[9 + i];
						o_sc_q[i] <= (status_q == ST_W_ZERO) ? '0 : sat_len(len_q[i]);
					end
					for (int i = 0; i < 4; i++)
						o_qt_q[i] <= (status_q == ST_OK) ? q_q[i] : '0;
					out_valid_q <= 1'b1;
					state_q     <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Result ports.
	assign out_valid     = out_valid_q;
	assign status        = o_status_q;
	assign translation_x = o_tr_q[0];
	assign translation_y = o_tr_q[1];
	assign translation_z = o_tr_q[2];
	assign scale_x       = o_sc_q[0];
	assign scale_y       = o_sc_q[1];
	assign scale_z       = o_sc_q[2];
	assign quat_x        = o_qt_q[0];
	assign quat_y        = o_qt_q[1];
	assign quat_z        = o_qt_q[2];
	assign quat_w        = o_qt_q[3];

endmodule

@@ sv/atd_checker.sv @@
module atd_checker #(
	parameter int DATA_WIDTH = 32
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_stall,
	input logic [3:0]                   element_index,
	input logic signed [DATA_WIDTH-1:0] element_value,
	input logic                         out_valid,
	input logic                         out_stall,
	input atd_pkg::status_t             status,
	input logic signed [DATA_WIDTH-1:0] translation_x,
	input logic signed [DATA_WIDTH-1:0] translation_y,
	input logic signed [DATA_WIDTH-1:0] translation_z,
	input logic [DATA_WIDTH-2:0]        scale_x,
	input logic [DATA_WIDTH-2:0]        scale_y,
	input logic [DATA_WIDTH-2:0]        scale_z,
	input logic signed [DATA_WIDTH-1:0] quat_x,
	input logic signed [DATA_WIDTH-1:0] quat_y,
	input logic signed [DATA_WIDTH-1:0] quat_z,
	input logic signed [DATA_WIDTH-1:0] quat_w
);
	import atd_pkg::*;

	// A stalled result blocks new items.
	a_stall_back: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |-> in_stall)
		else $error("item accepted while a result is stalled");

	// A trigger item keeps the input stalled in the next cycle.
	a_trigger_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && element_index == W_INDEX) |=> in_stall)
		else $error("input ready right after a trigger item");

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(status) && $stable(quat_w)))
		else $error("stalled result changed");

	// A zero w element clears the scales and the translation.
	a_w_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_W_ZERO) |->
		(scale_x == '0 && scale_y == '0 && scale_z == '0 && translation_x == '0))
		else $error("zero w element result not cleared");

	// Any failure status clears the quaternion.
	a_fail_quat: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != ST_OK) |->
		(quat_x == '0 && quat_y == '0 && quat_z == '0 && quat_w == '0))
		else $error("quaternion not cleared on failure");

endmodule

bind affine_transform_decompose atd_checker #(.DATA_WIDTH(DATA_WIDTH)) u_atd_checker (.*);

@@ tb/tb.sv @@
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import atd_pkg::*;

	localparam int DW = 32;
	localparam int FB = 16;
	localparam longint ONE = 64'sd1 << FB;
	localparam longint SMAX = 64'sd2147483647;
	localparam longint SMIN = -64'sd2147483648;
	localparam int CYCLE_LIMIT = 3000000;
	localparam int RANDOM_SEQS = 46;

	typedef struct {
		status_t st;
		logic signed [DW-1:0] tx, ty, tz;
		logic [DW-2:0] sx, sy, sz;
		logic signed [DW-1:0] qx, qy, qz, qw;
	} decomp_t;

	typedef struct {
		logic [3:0] idx;
		logic signed [DW-1:0] val;
		bit typed;
		decomp_t want;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [3:0] element_index;
	logic signed [DW-1:0] element_value;
	logic out_valid;
	logic out_stall;
	status_t status;
	logic signed [DW-1:0] translation_x, translation_y, translation_z;
	logic [DW-2:0] scale_x, scale_y, scale_z;
	logic signed [DW-1:0] quat_x, quat_y, quat_z, quat_w;

	// Model state: rows 0..2 of every column, slot column*3 + row.
	logic signed [DW-1:0] elem_store [12];
	decomp_t pending_decomps [$];
	int errors = 0;
	int results_seen = 0;
	int items_sent = 0;
	int cycles = 0;
	bit quiet = 1'b0;
	int status_hits [4];

	affine_transform_decompose dut (.*);

	always #4 clk = ~clk;

	function automatic longint unsigned mag(longint v);
		return v < 0 ? longint'(0) - v : v;
	endfunction

	function automatic longint unsigned root_floor(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint clamp(longint v);
		if (v > SMAX)
			return SMAX;
		if (v < SMIN)
			return SMIN;
		return v;
	endfunction

	function automatic longint quat_term(longint diff, longint unsigned root);
		longint unsigned q;
		q = (mag(diff) << FB) / (2 * root);
		return clamp(diff < 0 ? -longint'(q) : longint'(q));
	endfunction

	// Decomposition of the stored matrix, triggered by a nonzero or zero w element.
	function automatic decomp_t decompose(logic signed [DW-1:0] w);
		decomp_t d;
		longint n [9];
		longint q [4];
		longint unsigned len [3];
		longint unsigned s, root;
		longint x, tr, rad;
		int i, j, k;
		d = '{default: '0};
		q = '{default: 0};
		if (w == 0) begin
			d.st = ST_W_ZERO;
			return d;
		end
		d.st = ST_OK;
		for (int c = 0; c < 3; c++) begin
			s = 0;
			for (int r = 0; r < 3; r++)
				s += mag(elem_store[c*3+r]) * mag(elem_store[c*3+r]);
			len[c] = root_floor(s);
			for (int r = 0; r < 3; r++) begin
				x = elem_store[c*3+r];
				if (len[c] == 0) begin
					n[c*3+r] = 0;
				end else begin
					n[c*3+r] = longint'((mag(x) << FB) / len[c]);
					if (x < 0)
						n[c*3+r] = -n[c*3+r];
				end
			end
			if (len[c] == 0)
				d.st = ST_ZERO_COLUMN;
		end
		if (d.st == ST_OK) begin
			tr = n[0] + n[4] + n[8];
			if (tr > 0) begin
				root = root_floor(longint'(tr + ONE) << FB);
				q[3] = clamp(longint'(root >> 1));
				q[0] = quat_term(n[5] - n[7], root);
				q[1] = quat_term(n[6] - n[2], root);
				q[2] = quat_term(n[1] - n[3], root);
			end else begin
				i = 0;
				if (n[4] > n[0])
					i = 1;
				if (n[8] > n[i*4])
					i = 2;
				j = (i + 1) % 3;
				k = (j + 1) % 3;
				rad = n[i*4] - n[j*4] - n[k*4] + ONE;
				if (rad <= 0) begin
					d.st = ST_BAD_RADICAND;
				end else begin
					root = root_floor(longint'(rad) << FB);
					q[i] = clamp(longint'(root >> 1));
					q[j] = quat_term(n[i*3+j] + n[j*3+i], root);
					q[k] = quat_term(n[i*3+k] + n[k*3+i], root);
					q[3] = quat_term(n[j*3+k] - n[k*3+j], root);
				end
			end
			if (d.st != ST_OK)
				q = '{default: 0};
		end
		d.tx = elem_store[9];
		d.ty = elem_store[10];
		d.tz = elem_store[11];
		d.sx = (DW-1)'(len[0] > SMAX ? SMAX : len[0]);
		d.sy = (DW-1)'(len[1] > SMAX ? SMAX : len[1]);
		d.sz = (DW-1)'(len[2] > SMAX ? SMAX : len[2]);
		d.qx = DW'(q[0]);
		d.qy = DW'(q[1]);
		d.qz = DW'(q[2]);
		d.qw = DW'(q[3]);
		return d;
	endfunction

	// Drive one item and wait until it is taken; then update the model.
	task automatic send_element(logic [3:0] idx, logic signed [DW-1:0] val,
			bit typed = 0, decomp_t want = '{default: '0});
		decomp_t d;
		@(negedge clk);
		while (!quiet && $urandom_range(99) < 34) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		element_index <= idx;
		element_value <= val;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		items_sent++;
		if (idx == W_INDEX) begin
			d = decompose(val);
			pending_decomps.push_back(typed ? want : d);
		end else if (idx[1:0] != PERSP_ROW) begin
			elem_store[idx[3:2]*3 + idx[1:0]] = val;
		end
	endtask

	// Output stall pattern.
	always @(negedge clk)
		out_stall <= quiet ? 1'b0 : ($urandom_range(99) < 34);

	// Result checker.
	always @(posedge clk) begin
		decomp_t e;
		if (out_valid && !out_stall) begin
			results_seen++;
			if (pending_decomps.size() == 0) begin
				$error("unexpected result, status %0d", status);
				errors++;
			end else begin
				e = pending_decomps.pop_front();
				status_hits[e.st]++;
				if (status !== e.st) begin
					$error("status: expected %0d, got %0d", e.st, status); errors++;
				end
				if (translation_x !== e.tx) begin
					$error("translation_x: expected %0d, got %0d", e.tx, translation_x); errors++;
				end
				if (translation_y !== e.ty) begin
					$error("translation_y: expected %0d, got %0d", e.ty, translation_y); errors++;
				end
				if (translation_z !== e.tz) begin
					$error("translation_z: expected %0d, got %0d", e.tz, translation_z); errors++;
				end
				if (scale_x !== e.sx) begin
					$error("scale_x: expected %0d, got %0d", e.sx, scale_x); errors++;
				end
				if (scale_y !== e.sy) begin
					$error("scale_y: expected %0d, got %0d", e.sy, scale_y); errors++;
				end
				if (scale_z !== e.sz) begin
					$error("scale_z: expected %0d, got %0d", e.sz, scale_z); errors++;
				end
				if (quat_x !== e.qx) begin
					$error("quat_x: expected %0d, got %0d", e.qx, quat_x); errors++;
				end
				if (quat_y !== e.qy) begin
					$error("quat_y: expected %0d, got %0d", e.qy, quat_y); errors++;
				end
				if (quat_z !== e.qz) begin
					$error("quat_z: expected %0d, got %0d", e.qz, quat_z); errors++;
				end
				if (quat_w !== e.qw) begin
					$error("quat_w: expected %0d, got %0d", e.qw, quat_w); errors++;
				end
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("TEST FAILED");
			$finish;
		end
	end

	function automatic logic signed [DW-1:0] random_value(int flavor);
		case (flavor)
			0: return $urandom;
			1: return $signed($urandom_range(262143)) - 131072;
			default: return ($urandom_range(1) ? 65536 : -65536) + $signed($urandom_range(8191)) - 4096;
		endcase
	endfunction

	initial begin
		stim_row_t rows [$];
		decomp_t zc, wz, ident;
		int order [15];
		int flavor, zero_col, tmp, pick, cnt;
		logic signed [DW-1:0] v;

		arst_n = 1'b0;
		in_valid = 1'b0;
		out_stall = 1'b0;
		element_index = '0;
		element_value = '0;
		foreach (elem_store[i])
			elem_store[i] = '0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		// Directed part: fresh store, w zero, identity with translation, extremes.
		zc = '{default: '0};
		zc.st = ST_ZERO_COLUMN;
		wz = '{default: '0};
		wz.st = ST_W_ZERO;
		ident = '{default: '0};
		ident.st = ST_OK;
		ident.tx = 32'sh0007_0000;
		ident.ty = -32'sh0003_0000;
		ident.tz = 32'sh7fff_ffff;
		ident.sx = 31'd65536;
		ident.sy = 31'd65536;
		ident.sz = 31'd65536;
		ident.qw = 32'sd65536;
		rows = '{
			'{4'd15, 32'sd1, 1, zc},
			'{4'd15, 32'sd0, 1, wz},
			'{4'd0, 32'sd65536, 0, zc},
			'{4'd5, 32'sd65536, 0, zc},
			'{4'd10, 32'sd65536, 0, zc},
			'{4'd12, 32'sh0007_0000, 0, zc},
			'{4'd13, -32'sh0003_0000, 0, zc},
			'{4'd14, 32'sh7fff_ffff, 0, zc},
			'{4'd3, 32'sh7fff_ffff, 0, zc},
			'{4'd7, 32'sh8000_0000, 0, zc},
			'{4'd11, -32'sd1, 0, zc},
			'{4'd15, 32'sd65536, 1, ident},
			'{4'd15, -32'sd1, 0, zc},
			'{4'd0, 32'sh8000_0000, 0, zc},
			'{4'd1, 32'sh8000_0000, 0, zc},
			'{4'd2, 32'sh8000_0000, 0, zc},
			'{4'd4, 32'sh8000_0000, 0, zc},
			'{4'd6, 32'sh8000_0000, 0, zc},
			'{4'd8, 32'sh8000_0000, 0, zc},
			'{4'd9, 32'sh8000_0000, 0, zc},
			'{4'd15, 32'sh8000_0000, 0, zc},
			'{4'd5, 32'sh7fff_ffff, 0, zc},
			'{4'd10, 32'sh7fff_ffff, 0, zc},
			'{4'd15, 32'sh7fff_ffff, 0, zc}
		};
		foreach (rows[r])
			send_element(rows[r].idx, rows[r].val, rows[r].typed, rows[r].want);

		// Random part: mostly whole matrices in shuffled order, some loose noise.
		for (int s = 0; s < RANDOM_SEQS; s++) begin
			quiet = (s >= 14 && s < 22);
			if (s == 30) begin
				@(negedge clk);
				in_valid <= 1'b0;
				wait (pending_decomps.size() == 0);
				repeat (20) @(negedge clk);
			end
			if ($urandom_range(99) < 85) begin
				flavor = $urandom_range(2);
				zero_col = ($urandom_range(9) == 0) ? $urandom_range(2) : 3;
				for (int e = 0; e < 15; e++)
					order[e] = e;
				for (int e = 14; e > 0; e--) begin
					pick = $urandom_range(e);
					tmp = order[e];
					order[e] = order[pick];
					order[pick] = tmp;
				end
				foreach (order[e]) begin
					v = random_value(flavor);
					if (order[e] / 4 == zero_col)
						v = 0;
					send_element(4'(order[e]), v);
				end
				send_element(W_INDEX, ($urandom_range(9) == 0) ? 32'sd0 : random_value(0));
			end else begin
				cnt = $urandom_range(8, 1);
				for (int e = 0; e < cnt; e++)
					send_element(4'($urandom_range(14)), random_value($urandom_range(2)));
				if ($urandom_range(1))
					send_element(W_INDEX, random_value($urandom_range(2)));
			end
		end
		@(negedge clk);
		in_valid <= 1'b0;
		quiet = 1'b0;

		wait (pending_decomps.size() == 0);
		repeat (1000) @(posedge clk);
		$display("Sent %0d elements, checked %0d decompositions", items_sent, results_seen);
		$display("Status mix: ok %0d, w zero %0d, zero column %0d, bad radicand %0d",
			status_hits[0], status_hits[1], status_hits[2], status_hits[3]);
		if (errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
sv/atd_pkg.sv
sv/affine_transform_decompose.sv
sv/atd_checker.sv
tb/tb.sv
